// ----- sv/b64se_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b64se_pkg;

	// Command queue between the byte front end and the character back end.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [6:0] ASCII_UPPER_A = 7'h41;
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_ZERO    = 7'h30;
	localparam logic [6:0] ASCII_PLUS    = 7'h2B;
	localparam logic [6:0] ASCII_SLASH   = 7'h2F;
	localparam logic [6:0] ASCII_PAD     = 7'h3D;

	localparam logic [5:0] SEXTET_MASK   = 6'h3F;
	localparam logic [5:0] SEXTET_LOWER  = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT  = 6'd52;
	localparam logic [5:0] SEXTET_PLUS   = 6'd62;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} sym_t;

	// One accepted byte turns into one command of one to four symbols.
	typedef struct packed {
		logic           eom;
		logic [1:0]     last_idx;
		sym_t [3:0]     syms;
	} cmd_t;

	function automatic logic [6:0] b64_ascii(sym_t s);
		logic [6:0] v;
		logic [5:0] x;
		x = s.sextet & SEXTET_MASK;
		if (s.pad) begin
			v = ASCII_PAD;
		end else if (x < SEXTET_LOWER) begin
			v = ASCII_UPPER_A + {1'b0, x};
		end else if (x < SEXTET_DIGIT) begin
			v = ASCII_LOWER_A + {1'b0, x - SEXTET_LOWER};
		end else if (x < SEXTET_PLUS) begin
			v = ASCII_ZERO + {1'b0, x - SEXTET_DIGIT};
		end else if (x == SEXTET_PLUS) begin
			v = ASCII_PLUS;
		end else begin
			v = ASCII_SLASH;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- sv/base64_stream_encoder.sv -----
// Streaming base64 encoder with the standard alphabet and '=' padding.
// Input side is a queue: drive data_byte and end_of_message with push high;
// the byte transaction completes on a clock edge where full is low. Mark
// the last byte of each message with end_of_message.
// Output side is a queue too: while empty is low, ascii_char holds the
// oldest character and final_char flags the last character of a message;
// pop high on a clock edge takes it.
// The first character of a byte passes through the command queue and then
// the output register. The character stage emits one character per cycle
// while pop is high, so a byte yields one character (first or second byte
// of a group), two characters (third byte, or a message ending on the third
// byte), three or four characters (a message ending on the second or first
// byte). Long runs average four characters per three bytes; a two-entry
// command queue lets bytes keep arriving while characters are being sent.
// Reset clears the group phase, the leftover bits, both queues and the
// output valid flag. When pop is held low the output register keeps its
// character, the command queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
	import b64se_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	output logic            empty,
	input  wire logic       pop,
	output logic [6:0]      ascii_char,
	output logic            final_char
);

	cmd_t front_cmd, queue_cmd;
	logic cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;

	b64se_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.cmdq_full      (cmdq_full),
		.cmdq_push      (cmdq_push),
		.cmd            (front_cmd)
	);

	b64se_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmdq_push),
		.wr_cmd (front_cmd),
		.full   (cmdq_full),
		.rd_en  (cmdq_pop),
		.rd_cmd (queue_cmd),
		.empty  (cmdq_empty)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (queue_cmd),
		.cmd_empty  (cmdq_empty),
		.cmd_pop    (cmdq_pop),
		.empty      (empty),
		.pop        (pop),
		.ascii_char (ascii_char),
		.final_char (final_char)
	);

endmodule

`default_nettype wire

// ----- sv/b64se_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64se_front
	import b64se_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	input  wire logic       cmdq_full,
	output logic            cmdq_push,
	output cmd_t            cmd
);

	phase_t     phase_q, phase_d;
	logic [3:0] residue_q, residue_d;

	assign full      = cmdq_full;
	assign cmdq_push = push && !cmdq_full;

	always_comb begin
		cmd       = '0;
		cmd.eom   = end_of_message;
		phase_d   = phase_q;
		residue_d = residue_q;
		case (phase_q)
			PH_ONE: begin
				cmd.syms[0].sextet = {residue_q[1:0], data_byte[7:4]};
				if (end_of_message) begin
					cmd.syms[1].sextet = {data_byte[3:0], 2'b00};
					cmd.syms[2].pad    = 1'b1;
					cmd.last_idx       = 2'd2;
					phase_d            = PH_START;
					residue_d          = '0;
				end else begin
					cmd.last_idx = 2'd0;
					phase_d      = PH_TWO;
					residue_d    = data_byte[3:0];
				end
			end
			PH_TWO: begin
				cmd.syms[0].sextet = {residue_q, data_byte[7:6]};
				cmd.syms[1].sextet = data_byte[5:0];
				cmd.last_idx       = 2'd1;
				phase_d            = PH_START;
				residue_d          = '0;
			end
			default: begin
				cmd.syms[0].sextet = data_byte[7:2];
				if (end_of_message) begin
					cmd.syms[1].sextet = {data_byte[1:0], 4'b0000};
					cmd.syms[2].pad    = 1'b1;
					cmd.syms[3].pad    = 1'b1;
					cmd.last_idx       = 2'd3;
					phase_d            = PH_START;
					residue_d          = '0;
				end else begin
					cmd.last_idx = 2'd0;
					phase_d      = PH_ONE;
					residue_d    = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			residue_q <= '0;
		end else if (cmdq_push) begin
			phase_q   <= phase_d;
			residue_q <= residue_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/b64se_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64se_cmd_fifo
	import b64se_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_cmd,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_cmd,
	output logic      empty
);

	localparam logic [CMDQ_AW-1:0] PTR_LAST = CMDQ_AW'(CMDQ_DEPTH - 1);

	cmd_t                  store_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CMDQ_AW:0]      count_q;
	logic                  do_wr, do_rd;

	assign full   = (count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/b64se_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64se_back
	import b64se_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	input  wire logic       cmd_empty,
	output logic            cmd_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [6:0]      ascii_char,
	output logic            final_char
);

	logic       out_valid_q;
	logic [6:0] ascii_q;
	logic       final_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	// With a command waiting, the output register reloads when it is free or its transaction completes.
	assign load    = !cmd_empty && (!out_valid_q || pop);
	assign at_last = (idx_q == cmd.last_idx);
	assign cmd_pop = load && at_last;

	assign empty      = !out_valid_q;
	assign ascii_char = ascii_q;
	assign final_char = final_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ascii_q <= b64_ascii(cmd.syms[idx_q]);
			final_q <= cmd.eom && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_empty |-> idx_q <= cmd.last_idx)
		else $error("symbol index beyond the end of the command");

	a_mid_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !cmd_empty)
		else $error("command left the queue before all symbols were sent");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> idx_q == 2'd0)
		else $error("symbol index not rewound after a command finished");

endmodule

`default_nettype wire

// ----- tb/base64_stream_encoder_tb.sv -----
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
	import b64se_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 120;
	localparam int HOLD_TRIGGER = 40;

	typedef struct {
		logic [7:0] data;
		logic       eom;
		bit         drain_first;
	} byte_item_t;

	typedef struct {
		logic [6:0] ch;
		logic       fin;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_message = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [6:0] ascii_char;
	logic       final_char;

	byte_item_t pending_bytes[$];
	enc_char_t  expected_chars[$];

	// Encoder state mirrored on the testbench side.
	logic [3:0] leftover;
	phase_t     group_pos;

	string      b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	int         err_count = 0;
	int         bytes_sent = 0;

	base64_stream_encoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.empty          (empty),
		.pop            (pop),
		.ascii_char     (ascii_char),
		.final_char     (final_char)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void expect_sextet(logic [5:0] sextet, logic fin);
		enc_char_t c;
		byte       code;
		code = b64_alphabet[sextet];
		c.ch = code[6:0];
		c.fin = fin;
		expected_chars.insert(expected_chars.size(), c);
	endfunction

	function automatic void expect_pad(logic fin);
		enc_char_t c;
		c.ch = 7'h3D;
		c.fin = fin;
		expected_chars.insert(expected_chars.size(), c);
	endfunction

	// Works out the characters that one accepted byte produces.
	function automatic void encode_byte(logic [7:0] b, logic eom);
		case (group_pos)
			PH_ONE: begin
				expect_sextet({leftover[1:0], b[7:4]}, 1'b0);
				if (eom) begin
					expect_sextet({b[3:0], 2'b00}, 1'b0);
					expect_pad(1'b1);
					leftover = 4'h0;
					group_pos = PH_START;
				end else begin
					leftover = b[3:0];
					group_pos = PH_TWO;
				end
			end
			PH_TWO: begin
				expect_sextet({leftover, b[7:6]}, 1'b0);
				expect_sextet(b[5:0], eom);
				leftover = 4'h0;
				group_pos = PH_START;
			end
			default: begin
				expect_sextet(b[7:2], 1'b0);
				if (eom) begin
					expect_sextet({b[1:0], 4'h0}, 1'b0);
					expect_pad(1'b0);
					expect_pad(1'b1);
					leftover = 4'h0;
					group_pos = PH_START;
				end else begin
					leftover = {2'b00, b[1:0]};
					group_pos = PH_ONE;
				end
			end
		endcase
	endfunction

	function automatic void add_message(logic [7:0] bytes[$], bit drain_first);
		byte_item_t it;
		foreach (bytes[i]) begin
			it.data = bytes[i];
			it.eom = (i == bytes.size() - 1);
			it.drain_first = drain_first && (i == 0);
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endfunction

	// Driver: bursts of back-to-back transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin : driver
		int         burst_left;
		int         gap_left;
		byte_item_t it;
		if (!arst_n) begin
			push <= 1'b0;
			data_byte <= 8'h00;
			end_of_message <= 1'b0;
			leftover = 4'h0;
			group_pos = PH_START;
			burst_left = $urandom_range(1, 12);
			gap_left = 0;
		end else begin
			if (push && !full) begin
				encode_byte(data_byte, end_of_message);
				bytes_sent++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_bytes.size() > 0 &&
						!(pending_bytes[0].drain_first && expected_chars.size() > 0)) begin
					it = pending_bytes.pop_front();
					data_byte <= it.data;
					end_of_message <= it.eom;
					push <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks popped characters; drives pop high, by pattern or at random, with a hold.
	always @(posedge clk or negedge arst_n) begin : monitor
		enc_char_t  exp_c;
		int         mode;
		int         mode_left;
		logic [7:0] stall_pattern;
		int         hold_left;
		bit         hold_done;
		if (!arst_n) begin
			pop <= 1'b0;
			mode = 0;
			mode_left = 0;
			stall_pattern = 8'hFF;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					err_count++;
					$display("%0t: unexpected character: actual char=%02h final=%b",
						$time, ascii_char, final_char);
				end else begin
					exp_c = expected_chars.pop_front();
					if (ascii_char !== exp_c.ch || final_char !== exp_c.fin) begin
						err_count++;
						$display("%0t: mismatch: expected char=%02h final=%b, actual char=%02h final=%b",
							$time, exp_c.ch, exp_c.fin, ascii_char, final_char);
					end
				end
			end
			if (!hold_done && bytes_sent >= HOLD_TRIGGER) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left <= 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
				stall_pattern = 8'($urandom_range(1, 255));
			end
			mode_left--;
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= stall_pattern[0];
					default: pop <= ($urandom_range(0, 2) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else begin
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] msg[$];
		int         len;
		int         total;
		int         msg_no;
		// Single-byte messages at the extremes of the byte range.
		add_message('{8'h00}, 0);
		add_message('{8'hFF}, 0);
		// Message ending on the second byte of a group.
		add_message('{8'hFB, 8'hFF}, 0);
		add_message('{8'hFF, 8'hFF, 8'hFF}, 0);
		add_message('{8'h00, 8'h00, 8'h00}, 0);
		// Every sextet of the first group is 62, and the message ends on the first byte of a group.
		add_message('{8'hFB, 8'hEF, 8'hBE, 8'h4D}, 0);
		add_message('{8'h4D, 8'h61, 8'h6E, 8'h61, 8'h6E}, 0);
		total = 0;
		msg_no = 0;
		while (total < 100) begin
			msg.delete();
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 5))
					0: msg.insert(msg.size(), 8'h00);
					1: msg.insert(msg.size(), 8'hFF);
					default: msg.insert(msg.size(), 8'($urandom_range(0, 255)));
				endcase
			end
			// Part way through, the sender waits for the output to drain.
			add_message(msg, total < 60 && total + len >= 60);
			total += len;
			msg_no++;
		end
		@(posedge arst_n);
		@(posedge clk);
		while (pending_bytes.size() > 0 || push || expected_chars.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0 && expected_chars.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
